[design/vlcp_pkg.sv]
// shared types and constants of the variable length code packer
package vlcp_pkg;

  localparam int BYTE_W     = 8;
  localparam int FUNC_W     = 2;
  localparam int SYM_IN_W   = 8;
  localparam int CLEN_W     = 6;
  localparam int CODE_W     = 32;
  localparam int PEND_W     = BYTE_W - 1;
  localparam int PCNT_W     = 3;
  localparam int ACC_W      = CODE_W + PEND_W;
  localparam int TOT_W      = 6;
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int SYMBOLS_DEF      = 256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  // work handed from the lookup side to the bit packer
  typedef struct packed {
    logic              is_flush;
    logic [CLEN_W-1:0] len;
    logic [CODE_W-1:0] bits;
  } cmd_t;

endpackage

[design/vlcp_if.sv]
// channel interfaces: command items in, packed bytes out
interface vlcp_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [vlcp_pkg::FUNC_W-1:0]    func;
  logic [vlcp_pkg::SYM_IN_W-1:0]  symbol;
  logic [vlcp_pkg::CLEN_W-1:0]    code_length;
  logic [vlcp_pkg::CODE_W-1:0]    code_bits;

  modport source (output valid, func, symbol, code_length, code_bits, input ready);
  modport sink (input valid, func, symbol, code_length, code_bits, output ready);
endinterface

interface vlcp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [vlcp_pkg::BYTE_W-1:0]  packed_byte;
  logic                         last;

  modport source (output valid, packed_byte, last, input ready);
  modport sink (input valid, packed_byte, last, output ready);
endinterface

[design/vlcp_front.sv]
// front end: code table, lookup stage and command classification
module vlcp_front #(
  parameter int MAX_CODE_LEN = vlcp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOLS      = vlcp_pkg::SYMBOLS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  vlcp_cmd_if.sink           cmd,
  input  logic               q_full,
  output logic               q_push,
  output vlcp_pkg::cmd_t     q_data,
  output logic               busy
);

  localparam int CAP   = (MAX_CODE_LEN < vlcp_pkg::CODE_W) ? MAX_CODE_LEN : vlcp_pkg::CODE_W;
  localparam int LEN_W = $clog2(CAP + 1);
  localparam int SYM_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int SYM_CMP_W = vlcp_pkg::SYM_IN_W + 1;
  localparam logic [vlcp_pkg::CLEN_W-1:0] CAP_L = vlcp_pkg::CLEN_W'(CAP);

  logic [LEN_W-1:0]            len_mem [SYMBOLS];
  logic [vlcp_pkg::CODE_W-1:0] pat_mem [SYMBOLS];

  logic                        stage_valid;
  logic                        stage_valid_next;
  logic                        stage_flush;
  logic [LEN_W-1:0]            rd_len;
  logic [vlcp_pkg::CODE_W-1:0] rd_bits;

  logic                        accept;
  logic                        sym_ok;
  logic                        do_load;
  logic                        do_encode;
  logic                        do_flush;
  logic [vlcp_pkg::CLEN_W-1:0] capped_len;
  logic [SYM_W-1:0]            addr;

  assign cmd.ready = !stage_valid || !q_full;
  assign accept    = cmd.valid && cmd.ready;
  assign sym_ok    = SYM_CMP_W'(cmd.symbol) < SYM_CMP_W'(SYMBOLS);
  assign addr      = cmd.symbol[SYM_W-1:0];
  assign capped_len = (cmd.code_length > CAP_L) ? CAP_L : cmd.code_length;

  always_comb begin
    do_load   = 1'b0;
    do_encode = 1'b0;
    do_flush  = 1'b0;
    unique case (vlcp_pkg::func_t'(cmd.func))
      vlcp_pkg::FUNC_LOAD:   do_load   = accept && sym_ok;
      vlcp_pkg::FUNC_ENCODE: do_encode = accept && sym_ok;
      vlcp_pkg::FUNC_FLUSH:  do_flush  = accept;
      default: ;
    endcase
  end

  assign q_push = stage_valid && !q_full;
  assign q_data = '{is_flush: stage_flush,
                    len:      vlcp_pkg::CLEN_W'(rd_len),
                    bits:     rd_bits};
  assign busy   = stage_valid;

  always_comb begin
    stage_valid_next = stage_valid;
    if (do_encode || do_flush) begin
      stage_valid_next = 1'b1;
    end else if (q_push) begin
      stage_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_encode || do_flush) begin
      stage_flush <= do_flush;
    end
  end

  // code table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (do_load) begin
      len_mem[addr] <= capped_len[LEN_W-1:0];
      pat_mem[addr] <= cmd.code_bits;
    end
    if (do_encode) begin
      rd_len  <= len_mem[addr];
      rd_bits <= pat_mem[addr];
    end
  end

endmodule

[design/vlcp_queue.sv]
// short command queue between lookup and bit packer
module vlcp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vlcp_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output vlcp_pkg::cmd_t head,
  output logic           empty
);

  localparam int DEPTH = vlcp_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  vlcp_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = count == CNT_W'(DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[design/vlcp_back.sv]
// back end: bit accumulator and byte emitter
module vlcp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  vlcp_pkg::cmd_t q_head,
  output logic           q_pop,
  vlcp_byte_if.source    dst,
  output logic           busy
);

  localparam int ACC_W  = vlcp_pkg::ACC_W;
  localparam int TOT_W  = vlcp_pkg::TOT_W;
  localparam int PEND_W = vlcp_pkg::PEND_W;
  localparam int PCNT_W = vlcp_pkg::PCNT_W;
  localparam int BYTE_W = vlcp_pkg::BYTE_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t              state;
  logic [ACC_W-1:0]    work;
  logic [TOT_W-1:0]    total;
  logic [PEND_W-1:0]   pend;
  logic [PCNT_W-1:0]   pcnt;
  logic                ov;
  logic [BYTE_W-1:0]   ob;
  logic                ol;

  logic                out_free;
  logic                load_ov;
  logic [ACC_W-1:0]    code_mask;
  logic [ACC_W-1:0]    comb_bits;
  logic [TOT_W-1:0]    comb_total;
  logic [TOT_W-1:0]    rem;
  logic [BYTE_W-1:0]   flush_byte;
  logic [BYTE_W-1:0]   rem_mask;

  assign out_free  = !ov || dst.ready;
  assign dst.valid = ov;
  assign dst.packed_byte = ob;
  assign dst.last  = ol;
  assign busy      = state == ST_EMIT;

  assign q_pop = (state == ST_IDLE) && !q_empty && (!q_head.is_flush || out_free);

  // a new beat enters the output register
  assign load_ov = ((state == ST_IDLE) && q_pop && q_head.is_flush && (pcnt != '0)) ||
                   ((state == ST_EMIT) && out_free);

  // pending bits followed by the code, right aligned
  assign code_mask  = (ACC_W'(1) << q_head.len) - ACC_W'(1);
  assign comb_bits  = (ACC_W'(pend) << q_head.len) | (ACC_W'(q_head.bits) & code_mask);
  assign comb_total = TOT_W'(pcnt) + TOT_W'(q_head.len);

  // shift by 8 - pcnt, which is -pcnt modulo 8
  assign flush_byte = BYTE_W'({1'b0, pend} << (PCNT_W'(0) - pcnt));

  assign rem      = total - TOT_W'(BYTE_W);
  assign rem_mask = BYTE_W'((9'(1) << rem[PCNT_W-1:0]) - 9'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= '0;
      pcnt  <= '0;
      ov    <= 1'b0;
    end else begin
      if (load_ov) begin
        ov <= 1'b1;
      end else if (out_free) begin
        ov <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.is_flush) begin
              if (pcnt != '0) begin
                pend <= '0;
                pcnt <= '0;
              end
            end else if (comb_total >= TOT_W'(BYTE_W)) begin
              state <= ST_EMIT;
            end else begin
              pend <= comb_bits[PEND_W-1:0];
              pcnt <= comb_total[PCNT_W-1:0];
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (rem < TOT_W'(BYTE_W)) begin
              pend  <= work[PEND_W-1:0] & rem_mask[PEND_W-1:0];
              pcnt  <= rem[PCNT_W-1:0];
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (q_pop) begin
        work  <= comb_bits;
        total <= comb_total;
        // an encode must not disturb a beat still waiting at the output
        if (q_head.is_flush) begin
          ob <= flush_byte;
          ol <= 1'b1;
        end
      end
    end else if (out_free) begin
      ob    <= BYTE_W'(work >> rem);
      ol    <= rem < TOT_W'(BYTE_W);
      total <= rem;
    end
  end

endmodule

[design/variable_length_code_packer_top.sv]
// top level of the variable length code packer
//
//   channel   dir  beat payload                              handshake
//   cmd_ch    in   func, symbol, code_length, code_bits      valid/ready
//   byte_ch   out  packed_byte, last                         valid/ready
//
// the front takes one item a cycle unless a full queue holds it; a load
// writes the code table, an encode reads it through a registered read port
// and both encode and flush go to a two-entry queue. the packer takes one
// entry at a time and pops no other until it has emitted its full bytes;
// a flush emits at most one byte. reset clears the accumulator and
// control; the code table holds garbage until loaded. either side stalls
// on its own: a full queue holds cmd_ch, a held byte holds the packer.
module variable_length_code_packer_top #(
  parameter int MAX_CODE_LEN = vlcp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOLS      = vlcp_pkg::SYMBOLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  vlcp_cmd_if.sink    cmd_ch,
  vlcp_byte_if.source byte_ch
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  vlcp_pkg::cmd_t q_data;
  vlcp_pkg::cmd_t q_head;
  logic           front_busy;
  logic           back_busy;

  vlcp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOLS      (SYMBOLS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data),
    .busy   (front_busy)
  );

  vlcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  vlcp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .dst     (byte_ch),
    .busy    (back_busy)
  );

  // an accepted flush always reaches the lookup stage
  a_flush_staged: assert property (@(posedge clk) disable iff (rst)
    cmd_ch.valid && cmd_ch.ready &&
    (cmd_ch.func == vlcp_pkg::FUNC_FLUSH) |=> front_busy)
    else $error("flush not staged");

  // a byte that is not the last of its item leaves more bytes in the packer
  a_more_bytes: assert property (@(posedge clk) disable iff (rst)
    byte_ch.valid && !byte_ch.last |-> back_busy)
    else $error("non-final byte with packer idle");

  // the packer never pops while it is still emitting
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> !q_pop)
    else $error("queue popped while emitting");

endmodule

[tb/variable_length_code_packer_top_tb.sv]
`timescale 1ns / 100ps
// testbench of the variable length code packer: directed corners, random streams, back-to-back, output hold
module variable_length_code_packer_top_tb;

  localparam int FUNC_W   = vlcp_pkg::FUNC_W;
  localparam int BYTE_W   = vlcp_pkg::BYTE_W;
  localparam int SYM_IN_W = vlcp_pkg::SYM_IN_W;
  localparam int CLEN_W   = vlcp_pkg::CLEN_W;
  localparam int CODE_W   = vlcp_pkg::CODE_W;
  localparam int PEND_W   = vlcp_pkg::PEND_W;
  localparam int PCNT_W   = vlcp_pkg::PCNT_W;
  localparam int SYMBOLS_DEF = vlcp_pkg::SYMBOLS_DEF;
  localparam int MAX_CODE_LEN_DEF = vlcp_pkg::MAX_CODE_LEN_DEF;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int CODE_CAP = (MAX_CODE_LEN_DEF < CODE_W) ? MAX_CODE_LEN_DEF : CODE_W;
  localparam int RANDOM_ITEMS = 32;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 250000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_beat_t;

  logic clk = 1'b0;
  logic rst;

  vlcp_cmd_if  cmd_ch ();
  vlcp_byte_if byte_ch ();

  variable_length_code_packer_top dut (
    .clk     (clk),
    .rst     (rst),
    .cmd_ch  (cmd_ch),
    .byte_ch (byte_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CLEN_W-1:0] code_len_tab [SYMBOLS_DEF];
  logic [CODE_W-1:0] code_pat_tab [SYMBOLS_DEF];
  bit                sym_loaded   [SYMBOLS_DEF];
  int                loaded_syms  [$];
  logic [PEND_W-1:0] pend_bits;
  logic [PCNT_W-1:0] pend_cnt;

  packed_beat_t expected_bytes [$];
  int  errors = 0;
  int  cycle_count = 0;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  hold_reqs;
  int  hold_seen = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  // mostly short gaps, now and then a long one
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void predict_packed_bytes(logic [FUNC_W-1:0] f, logic [SYM_IN_W-1:0] sym,
                                               logic [CLEN_W-1:0] len, logic [CODE_W-1:0] bits);
    logic [BYTE_W-1:0] acc;
    int cnt;
    packed_beat_t beat;
    packed_beat_t fresh [$];
    case (f)
      vlcp_pkg::FUNC_LOAD: begin
        code_len_tab[sym] = (len > CODE_CAP) ? CLEN_W'(CODE_CAP) : len;
        code_pat_tab[sym] = bits;
        if (!sym_loaded[sym]) begin
          sym_loaded[sym] = 1'b1;
          loaded_syms.push_back(int'(sym));
        end
      end
      vlcp_pkg::FUNC_ENCODE: begin
        acc = {1'b0, pend_bits};
        cnt = pend_cnt;
        for (int i = code_len_tab[sym]; i > 0; i--) begin
          acc = {acc[BYTE_W-2:0], code_pat_tab[sym][i-1]};
          cnt++;
          if (cnt == BYTE_W) begin
            beat.data = acc;
            beat.last = 1'b0;
            fresh.push_back(beat);
            acc = '0;
            cnt = 0;
          end
        end
        pend_bits = acc[PEND_W-1:0];
        pend_cnt = PCNT_W'(cnt);
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
        foreach (fresh[k]) expected_bytes.push_back(fresh[k]);
      end
      vlcp_pkg::FUNC_FLUSH: begin
        if (pend_cnt != 0) begin
          // pad with zeros on the right
          beat.data = BYTE_W'({1'b0, pend_bits} << (BYTE_W - pend_cnt));
          beat.last = 1'b1;
          expected_bytes.push_back(beat);
          pend_bits = '0;
          pend_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // offer one item, return at the edge where it is taken; valid stays high
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [SYM_IN_W-1:0] sym,
                          input logic [CLEN_W-1:0] len, input logic [CODE_W-1:0] bits);
    int gap;
    gap = src_idle_en ? pick_idle_len() : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= f;
    cmd_ch.symbol      <= sym;
    cmd_ch.code_length <= len;
    cmd_ch.code_bits   <= bits;
    do @(posedge clk); while (!cmd_ch.ready);
    predict_packed_bytes(f, sym, len, bits);
  endtask

  task automatic send_random_item(output bit counted);
    int r;
    int lr;
    logic [CLEN_W-1:0] len;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (loaded_syms.size() == 0 || r < 20) begin
      lr = $urandom_range(0, 99);
      if (lr < 5) len = '0;
      else if (lr < 75) len = CLEN_W'($urandom_range(1, 12));
      else if (lr < 92) len = CLEN_W'($urandom_range(13, 32));
      else len = CLEN_W'($urandom_range(33, 63));
      send_cmd(vlcp_pkg::FUNC_LOAD, SYM_IN_W'($urandom_range(0, 255)), len, $urandom);
    end else if (r < 80) begin
      send_cmd(vlcp_pkg::FUNC_ENCODE,
               SYM_IN_W'(loaded_syms[$urandom_range(0, loaded_syms.size()-1)]),
               CLEN_W'($urandom), $urandom);
    end else if (r < 92) begin
      send_cmd(vlcp_pkg::FUNC_FLUSH, SYM_IN_W'($urandom), CLEN_W'($urandom), $urandom);
    end else begin
      send_cmd(FUNC_UNUSED, SYM_IN_W'($urandom), CLEN_W'($urandom), $urandom);
      counted = 1'b0;
    end
  endtask

  task automatic check_packed_byte(input logic [BYTE_W-1:0] data, input logic last);
    packed_beat_t want;
    if (expected_bytes.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("unexpected beat: packed_byte %h last %b", data, last);
    end else begin
      want = expected_bytes.pop_front();
      if (data !== want.data || last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: packed_byte exp %h got %h, last exp %b got %b",
                   want.data, data, want.last, last);
      end
    end
  endtask

  // receiver: checks every beat and decides ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.ready <= 1'b0;
    end else begin
      if (byte_ch.valid && byte_ch.ready) check_packed_byte(byte_ch.packed_byte, byte_ch.last);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        byte_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        byte_ch.ready <= 1'b0;
      end else if (sink_idle_en) begin
        stall_left = pick_idle_len();
        byte_ch.ready <= (stall_left == 0);
      end else begin
        byte_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed_corners();
    send_cmd(vlcp_pkg::FUNC_FLUSH, 8'h00, 6'h00, 32'h0);            // nothing pending
    send_cmd(FUNC_UNUSED, 8'hFF, 6'h3F, 32'hFFFF_FFFF);
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'h00, 6'd1, 32'h0000_0001);
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'h55, 6'd0, 32'hDEAD_BEEF);      // zero-length code
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'hAA, 6'd63, 32'hA5A5_A5A5);     // saturates to 32
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'h7F, 6'd33, 32'h0F0F_00FF);
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'h01, 6'd7, 32'h0000_0055);
    send_cmd(vlcp_pkg::FUNC_LOAD, 8'h80, 6'd32, 32'h0000_0000);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'h00, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_FLUSH, 8'h00, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_FLUSH, 8'h00, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'hFF, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'h55, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'h01, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'hAA, 6'h00, 32'h0);           // 7 pending + 32 bits
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'h7F, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'h80, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_ENCODE, 8'h00, 6'h00, 32'h0);
    send_cmd(FUNC_UNUSED, 8'h00, 6'h00, 32'h0);
    send_cmd(vlcp_pkg::FUNC_FLUSH, 8'h00, 6'h00, 32'h0);
  endtask

  task automatic test_random_stream();
    int sent;
    bit counted;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_random_item(counted);
      if (counted) sent++;
    end
  endtask

  task automatic test_back_to_back();
    bit counted;
    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    repeat (40) send_random_item(counted);
    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
  endtask

  // receiver holds off while encodes keep coming, so the input has to stall
  task automatic test_output_hold();
    src_idle_en = 1'b0;
    hold_reqs <= hold_reqs + 1;
    repeat (24)
      send_cmd(vlcp_pkg::FUNC_ENCODE,
               SYM_IN_W'(loaded_syms[$urandom_range(0, loaded_syms.size()-1)]),
               CLEN_W'($urandom), $urandom);
    send_cmd(vlcp_pkg::FUNC_FLUSH, SYM_IN_W'($urandom), CLEN_W'($urandom), $urandom);
    src_idle_en = 1'b1;
  endtask

  initial begin
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= vlcp_pkg::FUNC_LOAD;
    cmd_ch.symbol      <= '0;
    cmd_ch.code_length <= '0;
    cmd_ch.code_bits   <= '0;
    hold_reqs          <= 0;
    sink_idle_en       <= 1'b1;
    src_idle_en = 1'b1;
    pend_bits = '0;
    pend_cnt = '0;
    foreach (sym_loaded[i]) begin
      sym_loaded[i] = 1'b0;
      code_len_tab[i] = '0;
      code_pat_tab[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_corners();
    test_random_stream();
    test_back_to_back();
    test_output_hold();
    test_random_stream();

    cmd_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
